### design/lsar_pkg.sv
// Shared types, constants and helper functions for the light sensor autorange block.
// No dependencies; compiled first.
`default_nettype none

package lsar_pkg;

    // Gain codes
    localparam logic [2:0] GAIN_X1   = 3'd0;
    localparam logic [2:0] GAIN_X2   = 3'd1;
    localparam logic [2:0] GAIN_X1_8 = 3'd2;
    localparam logic [2:0] GAIN_X1_4 = 3'd3;

    // Integration time codes
    localparam logic [2:0] TIME_25MS  = 3'd0;
    localparam logic [2:0] TIME_50MS  = 3'd1;
    localparam logic [2:0] TIME_100MS = 3'd2;
    localparam logic [2:0] TIME_200MS = 3'd3;
    localparam logic [2:0] TIME_400MS = 3'd4;
    localparam logic [2:0] TIME_800MS = 3'd5;

    // Operation codes
    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_SET     = 1'b1;

    // Register map (index = paddr[2])
    localparam int unsigned  PADDR_W      = 3;
    localparam logic         REG_LOW_THR  = 1'b0;
    localparam logic         REG_HIGH_THR = 1'b1;
    localparam logic [15:0]  LOW_THR_RST  = 16'd100;
    localparam logic [15:0]  HIGH_THR_RST = 16'd20000;

    // Resolution is 3600 microlux << shift; count * 3600 / 1000 = count * 18 / 5.
    // Division by 5 uses reciprocal multiplies, exact over the value ranges below.
    localparam int unsigned  X_W      = 21;            // count * 18 < 2^21
    localparam int unsigned  RECIP_W  = 22;
    localparam logic [RECIP_W-1:0] RECIP_X = 22'd3355444; // ceil(2^24 / 5)
    localparam int unsigned  RECIP_X_SH = 24;
    localparam int unsigned  PROD_W   = X_W + RECIP_W;
    localparam int unsigned  Q_W      = 18;
    localparam int unsigned  Y_W      = 12;            // rem << shift < 2^12
    localparam logic [12:0]  RECIP_Y  = 13'd6554;      // ceil(2^15 / 5)
    localparam int unsigned  RECIP_Y_SH = 15;
    localparam int unsigned  LUX_W    = 27;

    // Queue between front and back
    localparam int unsigned  FIFO_DEPTH = 2;
    localparam int unsigned  FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic        lux_calc;
        logic        switched;
        logic        err;
        logic [2:0]  gain_now;
        logic [2:0]  int_time_now;
        logic [3:0]  shift;
        logic [15:0] als;
        logic [15:0] white;
    } lsar_item_t;

    // 1 when the gain/time pair has a defined resolution
    function automatic logic setting_ok(input logic [2:0] g, input logic [2:0] t);
        logic ok;
        begin
            ok = (g <= GAIN_X1_4) && (t <= TIME_800MS);
            return ok;
        end
    endfunction

    // Shift applied to 3600 microlux for a valid setting
    function automatic logic [3:0] res_shift(input logic [2:0] g, input logic [2:0] t);
        logic [3:0] base;
        begin
            case (g)
                GAIN_X1:   base = 4'd6;
                GAIN_X2:   base = 4'd5;
                GAIN_X1_8: base = 4'd9;
                GAIN_X1_4: base = 4'd8;
                default:   base = 4'd0;
            endcase
            return base - {1'b0, t};
        end
    endfunction

endpackage

`default_nettype wire

### design/lsar_if.sv
// Valid/ready channel interfaces for sample input and result output.
// Depends on nothing; compiled after lsar_pkg.
`default_nettype none

interface lsar_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] raw_als;
    logic [15:0] white_count;
    logic [2:0]  new_gain;
    logic [2:0]  new_int_time;

    modport source (output valid, operation, raw_als, white_count, new_gain, new_int_time,
                    input ready);
    modport sink   (input valid, operation, raw_als, white_count, new_gain, new_int_time,
                    output ready);
endinterface

interface lsar_out_if;
    logic        valid;
    logic        ready;
    logic [26:0] als_millilux;
    logic [26:0] white_millilux;
    logic        lux_valid;
    logic        range_switched;
    logic        setting_error;
    logic [2:0]  gain_now;
    logic [2:0]  int_time_now;

    modport source (output valid, als_millilux, white_millilux, lux_valid, range_switched,
                    setting_error, gain_now, int_time_now,
                    input ready);
    modport sink   (input valid, als_millilux, white_millilux, lux_valid, range_switched,
                    setting_error, gain_now, int_time_now,
                    output ready);
endinterface

`default_nettype wire

### design/lsar_front.sv
// Front end: APB threshold registers, range state and per-sample classification.
// Depends on lsar_pkg and lsar_in_if.
`default_nettype none

module lsar_front
    import lsar_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    lsar_in_if.sink                 sample,
    input  wire logic               fifo_full,
    output logic                    push,
    output lsar_item_t              push_item
);

    logic [15:0] low_thr_reg, low_thr_next;
    logic [15:0] high_thr_reg, high_thr_next;
    logic [2:0]  gain_reg, gain_next;
    logic [2:0]  time_reg, time_next;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_HIGH_THR) ? {16'd0, high_thr_reg} : {16'd0, low_thr_reg};

    always_comb
    begin
        low_thr_next  = low_thr_reg;
        high_thr_next = high_thr_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_LOW_THR:  low_thr_next  = pwdata[15:0];
                REG_HIGH_THR: high_thr_next = pwdata[15:0];
                default:      low_thr_next  = low_thr_reg;
            endcase
        end
    end

    assign sample.ready = !fifo_full;
    assign push         = sample.valid && sample.ready;

    // Classify: set, switch low, switch high, or convert (error if the setting is undefined)
    always_comb
    begin
        gain_next          = gain_reg;
        time_next          = time_reg;
        push_item.lux_calc = 1'b0;
        push_item.switched = 1'b0;
        push_item.err      = 1'b0;
        if (sample.operation == OP_SET)
        begin
            gain_next     = sample.new_gain;
            time_next     = sample.new_int_time;
            push_item.err = !setting_ok(sample.new_gain, sample.new_int_time);
        end
        else if ((sample.raw_als < low_thr_reg) && (gain_reg != GAIN_X2))
        begin
            gain_next          = GAIN_X2;
            time_next          = TIME_800MS;
            push_item.switched = 1'b1;
        end
        else if ((sample.raw_als > high_thr_reg) && (gain_reg != GAIN_X1_8))
        begin
            gain_next          = GAIN_X1_8;
            time_next          = TIME_25MS;
            push_item.switched = 1'b1;
        end
        else
        begin
            push_item.lux_calc = setting_ok(gain_reg, time_reg);
            push_item.err      = !setting_ok(gain_reg, time_reg);
        end
        push_item.gain_now     = gain_next;
        push_item.int_time_now = time_next;
        push_item.shift        = res_shift(gain_reg, time_reg);
        push_item.als          = sample.raw_als;
        push_item.white        = sample.white_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg  <= LOW_THR_RST;
            high_thr_reg <= HIGH_THR_RST;
            gain_reg     <= GAIN_X1;
            time_reg     <= TIME_100MS;
        end
        else
        begin
            low_thr_reg  <= low_thr_next;
            high_thr_reg <= high_thr_next;
            if (push)
            begin
                gain_reg <= gain_next;
                time_reg <= time_next;
            end
        end
    end

endmodule

`default_nettype wire

### design/lsar_fifo.sv
// Two-entry queue of classified items between front and back.
// Depends on lsar_pkg.
`default_nettype none

module lsar_fifo
    import lsar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  lsar_item_t       push_item,
    output logic             full,
    output logic             not_empty,
    input  wire logic        pop,
    output lsar_item_t       pop_item
);

    lsar_item_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]         count_reg, count_next;

    assign full      = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### design/lsar_back.sv
// Back end: two-stage millilux conversion pipeline (multiply stage, then output register).
// Depends on lsar_pkg and lsar_out_if.
`default_nettype none

module lsar_back
    import lsar_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   not_empty,
    input  lsar_item_t  pop_item,
    output logic        pop,
    lsar_out_if.source  result
);

    logic                s1_v_reg;
    lsar_item_t          s1_item_reg;
    logic [X_W-1:0]      s1_als_x_reg, s1_white_x_reg;
    logic [PROD_W-1:0]   s1_als_p_reg, s1_white_p_reg;
    logic [X_W-1:0]      als_x, white_x;
    logic                out_v_reg;
    logic [LUX_W-1:0]    als_ml_reg, white_ml_reg, als_ml, white_ml;
    logic                lux_valid_reg, switched_reg, err_reg;
    logic [2:0]          gain_reg, time_reg;
    logic                out_free, s1_free;

    // floor(x * 2^shift / 5) from x and x * RECIP_X
    function automatic logic [LUX_W-1:0] finish(input logic [X_W-1:0] x,
                                                input logic [PROD_W-1:0] p,
                                                input logic [3:0] sh);
        logic [Q_W-1:0]  q;
        logic [X_W-1:0]  q5;
        logic [2:0]      rem;
        logic [Y_W-1:0]  y;
        logic [24:0]     yp;
        begin
            q   = p[RECIP_X_SH +: Q_W];
            q5  = X_W'({q, 2'b00}) + X_W'(q);
            rem = 3'(x - q5);
            y   = Y_W'(rem) << sh;
            yp  = y * RECIP_Y;
            return (LUX_W'(q) << sh) + LUX_W'(yp[24:RECIP_Y_SH]);
        end
    endfunction

    assign out_free = !out_v_reg || result.ready;
    assign s1_free  = !s1_v_reg || out_free;
    assign pop      = not_empty && s1_free;

    // count * 18
    assign als_x   = X_W'({pop_item.als, 4'b0000}) + X_W'({pop_item.als, 1'b0});
    assign white_x = X_W'({pop_item.white, 4'b0000}) + X_W'({pop_item.white, 1'b0});

    assign als_ml   = finish(s1_als_x_reg, s1_als_p_reg, s1_item_reg.shift);
    assign white_ml = finish(s1_white_x_reg, s1_white_p_reg, s1_item_reg.shift);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_item_reg    <= pop_item;
            s1_als_x_reg   <= als_x;
            s1_white_x_reg <= white_x;
            s1_als_p_reg   <= als_x * RECIP_X;
            s1_white_p_reg <= white_x * RECIP_X;
        end
        if (s1_v_reg && out_free)
        begin
            als_ml_reg    <= s1_item_reg.lux_calc ? als_ml : '0;
            white_ml_reg  <= s1_item_reg.lux_calc ? white_ml : '0;
            lux_valid_reg <= s1_item_reg.lux_calc;
            switched_reg  <= s1_item_reg.switched;
            err_reg       <= s1_item_reg.err;
            gain_reg      <= s1_item_reg.gain_now;
            time_reg      <= s1_item_reg.int_time_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_v_reg <= pop;
            if (out_free)
                out_v_reg <= s1_v_reg;
        end
    end

    assign result.valid          = out_v_reg;
    assign result.als_millilux   = als_ml_reg;
    assign result.white_millilux = white_ml_reg;
    assign result.lux_valid      = lux_valid_reg;
    assign result.range_switched = switched_reg;
    assign result.setting_error  = err_reg;
    assign result.gain_now       = gain_reg;
    assign result.int_time_now   = time_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> ($countones({lux_valid_reg, switched_reg, err_reg}) <= 1))
        else $error("conflicting result flags");

    a_no_lux_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !lux_valid_reg) |-> (als_ml_reg == '0 && white_ml_reg == '0))
        else $error("lux nonzero without lux_valid");

    a_switch_target: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && switched_reg) |->
            ((gain_reg == GAIN_X2 && time_reg == TIME_800MS) ||
             (gain_reg == GAIN_X1_8 && time_reg == TIME_25MS)))
        else $error("range switch to unexpected setting");

endmodule

`default_nettype wire

### design/light_sensor_autorange_lux.sv
// Top level of the ambient light autorange and millilux converter.
// Depends on lsar_pkg, lsar_if, lsar_front, lsar_fifo and lsar_back.
//
//  port     | dir | protocol    | content
//  ---------+-----+-------------+---------------------------------------------
//  sample   | in  | valid/ready | operation, raw counts, new gain/time codes
//  result   | out | valid/ready | millilux pair, flags, gain/time in effect
//  apb      | in  | APB rd/wr   | low_threshold @0x0, high_threshold @0x4
//
// One sample transfer per cycle sustained while results are taken; each result
// is registered through the queue, multiply stage and output register in turn.
// Range state updates at the input transfer, so back-to-back samples see it.
// Reset: gain x1, 100 ms, thresholds 100 and 20000, queue and pipeline empty.
// Output stalls back up through the pipeline into the two-entry queue; sample
// ready drops only when that queue is full.
`default_nettype none

module light_sensor_autorange_lux
    import lsar_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    lsar_in_if.sink                 sample,
    lsar_out_if.source              result
);

    logic       fifo_full, fifo_not_empty, push, pop;
    lsar_item_t push_item, pop_item;

    lsar_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sample    (sample),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    lsar_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .pop       (pop),
        .pop_item  (pop_item)
    );

    lsar_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (fifo_not_empty),
        .pop_item  (pop_item),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

### tb/light_sensor_autorange_lux_test.sv
// Self-checking testbench for light_sensor_autorange_lux: directed table, then random traffic.
// Needs lsar_pkg, lsar_if and the design; checks typed rows or an in-bench predictor.
`timescale 1ns / 100ps

module light_sensor_autorange_lux_test
    import lsar_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SEG_ITEMS     = 125;
    localparam int unsigned NUM_SEGS      = 6;

    localparam logic [PADDR_W-1:0] LOW_THR_ADDR  = PADDR_W'(4 * REG_LOW_THR);
    localparam logic [PADDR_W-1:0] HIGH_THR_ADDR = PADDR_W'(4 * REG_HIGH_THR);

    // Codes outside the defined gain and time sets
    localparam logic [2:0] GAIN_BAD_LO = 3'd4;
    localparam logic [2:0] GAIN_BAD_HI = 3'd7;
    localparam logic [2:0] TIME_BAD_LO = 3'd6;
    localparam logic [2:0] TIME_BAD_HI = 3'd7;

    // Microlux per count at 100 ms
    localparam longint unsigned UL_X1   = 57600;
    localparam longint unsigned UL_X2   = 28800;
    localparam longint unsigned UL_X1_8 = 460800;
    localparam longint unsigned UL_X1_4 = 230400;

    localparam bit PREDICTED = 1'b0;
    localparam bit TYPED     = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] als;
        logic [15:0] white;
        logic [2:0]  gain;
        logic [2:0]  itime;
    } sample_t;

    typedef struct packed {
        logic [26:0] als_ml;
        logic [26:0] white_ml;
        logic        lux_valid;
        logic        switched;
        logic        err;
        logic [2:0]  gain;
        logic [2:0]  itime;
    } lux_result_t;

    typedef struct packed {
        sample_t     s;
        bit          typed;
        lux_result_t want;
    } dir_row_t;

    localparam int NUM_ROWS     = 26;
    localparam int BOTH_HIT_ROW = 23;

    dir_row_t directed_rows [NUM_ROWS] = '{
        '{'{OP_PROCESS, 16'd1000, 16'd2000, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd57600, 27'd115200, 1'b1, 1'b0, 1'b0, GAIN_X1, TIME_100MS}},
        '{'{OP_PROCESS, 16'd0, 16'd65535, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X2, TIME_800MS}},
        '{'{OP_PROCESS, 16'd0, 16'd65535, GAIN_X1, TIME_25MS}, PREDICTED, '0},
        '{'{OP_PROCESS, 16'd65535, 16'd0, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X1_8, TIME_25MS}},
        '{'{OP_PROCESS, 16'd65535, 16'd65535, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd120794112, 27'd120794112, 1'b1, 1'b0, 1'b0, GAIN_X1_8, TIME_25MS}},
        '{'{OP_SET, 16'd65535, 16'd65535, GAIN_BAD_HI, TIME_BAD_HI}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b1, GAIN_BAD_HI, TIME_BAD_HI}},
        '{'{OP_PROCESS, 16'd5000, 16'd5000, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b1, GAIN_BAD_HI, TIME_BAD_HI}},
        '{'{OP_PROCESS, 16'd50, 16'd50, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X2, TIME_800MS}},
        '{'{OP_SET, 16'd0, 16'd0, GAIN_BAD_LO, TIME_200MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b1, GAIN_BAD_LO, TIME_200MS}},
        '{'{OP_PROCESS, 16'd30000, 16'd1, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X1_8, TIME_25MS}},
        '{'{OP_SET, 16'd0, 16'd0, GAIN_X1, TIME_BAD_LO}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b1, GAIN_X1, TIME_BAD_LO}},
        '{'{OP_PROCESS, 16'd20000, 16'd1, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b1, GAIN_X1, TIME_BAD_LO}},
        '{'{OP_SET, 16'd0, 16'd0, GAIN_X1_4, TIME_800MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b0, GAIN_X1_4, TIME_800MS}},
        '{'{OP_PROCESS, 16'd100, 16'd12345, GAIN_X1, TIME_25MS}, PREDICTED, '0},
        '{'{OP_SET, 16'd0, 16'd0, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b0, GAIN_X1, TIME_25MS}},
        '{'{OP_PROCESS, 16'd99, 16'd0, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X2, TIME_800MS}},
        '{'{OP_PROCESS, 16'd20001, 16'd0, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X1_8, TIME_25MS}},
        '{'{OP_SET, 16'd43690, 16'd21845, GAIN_X2, TIME_50MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b0, GAIN_X2, TIME_50MS}},
        '{'{OP_PROCESS, 16'd777, 16'd4321, GAIN_X1, TIME_25MS}, PREDICTED, '0},
        '{'{OP_SET, 16'd0, 16'd0, GAIN_X1_4, TIME_400MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b0, GAIN_X1_4, TIME_400MS}},
        '{'{OP_PROCESS, 16'd20000, 16'd65535, GAIN_X1, TIME_25MS}, PREDICTED, '0},
        '{'{OP_SET, 16'd0, 16'd0, GAIN_X1, TIME_200MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b0, 1'b0, GAIN_X1, TIME_200MS}},
        '{'{OP_PROCESS, 16'd1234, 16'd54321, GAIN_X1, TIME_25MS}, PREDICTED, '0},
        // thresholds crossed (low 60000, high 10): low test wins unless gain is x2
        '{'{OP_PROCESS, 16'd5000, 16'd5000, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X2, TIME_800MS}},
        '{'{OP_PROCESS, 16'd5000, 16'd5000, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X1_8, TIME_25MS}},
        '{'{OP_PROCESS, 16'd5000, 16'd5000, GAIN_X1, TIME_25MS}, TYPED,
          '{27'd0, 27'd0, 1'b0, 1'b1, 1'b0, GAIN_X2, TIME_800MS}}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    lsar_in_if  sample_ch();
    lsar_out_if result_ch();

    light_sensor_autorange_lux dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    always #1 clk = ~clk;

    // Predictor state
    logic [2:0]  cur_gain  = GAIN_X1;
    logic [2:0]  cur_itime = TIME_100MS;
    logic [15:0] thr_low   = LOW_THR_RST;
    logic [15:0] thr_high  = HIGH_THR_RST;

    lux_result_t pending_results [$];
    int          mismatches    = 0;
    int unsigned cycles        = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_left     = 0;
    bit          stall_request = 1'b0;

    function automatic longint unsigned micro_per_count(input logic [2:0] g,
                                                        input logic [2:0] t);
        longint unsigned base;
        case (g)
            GAIN_X1:   base = UL_X1;
            GAIN_X2:   base = UL_X2;
            GAIN_X1_8: base = UL_X1_8;
            GAIN_X1_4: base = UL_X1_4;
            default:   base = 0;
        endcase
        case (t)
            TIME_25MS:  return base * 4;
            TIME_50MS:  return base * 2;
            TIME_100MS: return base;
            TIME_200MS: return base / 2;
            TIME_400MS: return base / 4;
            TIME_800MS: return base / 8;
            default:    return 0;
        endcase
    endfunction

    // Advances the range state by one accepted sample and returns its result
    function automatic lux_result_t predict_step(input sample_t s);
        lux_result_t     r;
        longint unsigned ul;
        r = '0;
        if (s.op == OP_SET) begin
            cur_gain  = s.gain;
            cur_itime = s.itime;
            r.err     = (micro_per_count(s.gain, s.itime) == 0);
        end
        else if (s.als < thr_low && cur_gain != GAIN_X2) begin
            cur_gain   = GAIN_X2;
            cur_itime  = TIME_800MS;
            r.switched = 1'b1;
        end
        else if (s.als > thr_high && cur_gain != GAIN_X1_8) begin
            cur_gain   = GAIN_X1_8;
            cur_itime  = TIME_25MS;
            r.switched = 1'b1;
        end
        else begin
            ul = micro_per_count(cur_gain, cur_itime);
            if (ul == 0)
                r.err = 1'b1;
            else
            begin
                r.als_ml    = 27'((64'(s.als) * ul) / 1000);
                r.white_ml  = 27'((64'(s.white) * ul) / 1000);
                r.lux_valid = 1'b1;
            end
        end
        r.gain  = cur_gain;
        r.itime = cur_itime;
        return r;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      a;
        int      mode;
        s.op    = ($urandom_range(99) < 15) ? OP_SET : OP_PROCESS;
        s.white = 16'($urandom);
        s.gain  = ($urandom_range(99) < 80) ? 3'($urandom_range(3)) : 3'($urandom_range(7));
        s.itime = ($urandom_range(99) < 80) ? 3'($urandom_range(5)) : 3'($urandom_range(7));
        mode = $urandom_range(99);
        if (mode < 35)
            a = $urandom_range(65535);
        else if (mode < 65)
            a = (thr_low <= thr_high) ? int'($urandom_range(thr_high, thr_low))
                                      : int'($urandom_range(65535));
        else if (mode < 80)
            a = int'(thr_low) + int'($urandom_range(4)) - 2;
        else
            a = int'(thr_high) + int'($urandom_range(4)) - 2;
        if (a < 0)
            a = 0;
        if (a > 65535)
            a = 65535;
        s.als = 16'(a);
        return s;
    endfunction

    task automatic check_field(input string name, input logic [26:0] want,
                               input logic [26:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
            mismatches++;
        end
    endtask

    task automatic check_result();
        lux_result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result transfer with nothing pending", $time);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("als_millilux", want.als_ml, result_ch.als_millilux);
            check_field("white_millilux", want.white_ml, result_ch.white_millilux);
            check_field("lux_valid", 27'(want.lux_valid), 27'(result_ch.lux_valid));
            check_field("range_switched", 27'(want.switched), 27'(result_ch.range_switched));
            check_field("setting_error", 27'(want.err), 27'(result_ch.setting_error));
            check_field("gain_now", 27'(want.gain), 27'(result_ch.gain_now));
            check_field("int_time_now", 27'(want.itime), 27'(result_ch.int_time_now));
        end
    endtask

    // Result side: check each transfer, then pick ready for the next cycle
    always @(posedge clk) begin
        if (result_ch.valid && result_ch.ready)
            check_result();
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("light_sensor_autorange_lux_test NOT OK");
            $finish;
        end
    end

    task automatic transfer_sample(input sample_t s, input bit typed, input lux_result_t want);
        lux_result_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.operation    <= s.op;
        sample_ch.raw_als      <= s.als;
        sample_ch.white_count  <= s.white;
        sample_ch.new_gain     <= s.gain;
        sample_ch.new_int_time <= s.itime;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pred = predict_step(s);
        pending_results.push_back(typed ? want : pred);
    endtask

    // Drop valid and let every pending result drain
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == LOW_THR_ADDR)
            thr_low = value;
        else
            thr_high = value;
        @(posedge clk);
        // read back
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("prdata", 27'(value), 27'(prdata));
        if (prdata[31:16] !== 16'd0) begin
            $display("%0t: prdata upper expected 0 got %0h", $time, prdata[31:16]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        int unsigned lo;
        int unsigned hi;
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.operation    = OP_PROCESS;
        sample_ch.raw_als      = '0;
        sample_ch.white_count  = '0;
        sample_ch.new_gain     = GAIN_X1;
        sample_ch.new_int_time = TIME_25MS;
        result_ch.ready        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 19;
        recv_idle_pct = 52;
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (i == BOTH_HIT_ROW) begin
                settle();
                write_reg(LOW_THR_ADDR, 16'd60000);
                write_reg(HIGH_THR_ADDR, 16'd10);
            end
            transfer_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            settle();
            case (seg)
                0: begin lo = 100;   hi = 20000; end
                1: begin lo = 0;     hi = 65535; end
                2: begin lo = 65535; hi = 0;     end
                3: begin
                    lo = $urandom_range(30000);
                    hi = $urandom_range(65535, lo);
                end
                4: begin lo = 1000;  hi = 1000;  end
                default: begin
                    lo = $urandom_range(65535);
                    hi = $urandom_range(65535);
                end
            endcase
            write_reg(LOW_THR_ADDR, 16'(lo));
            write_reg(HIGH_THR_ADDR, 16'(hi));
            send_idle_pct = (seg < 2) ? 19 : (seg < 4) ? 52 : 0;
            recv_idle_pct = (seg < 2) ? 52 : (seg < 4) ? 19 : 0;
            // long output stall while samples keep coming: queue fills, input backs up
            if (seg == 4)
                stall_request = 1'b1;
            repeat (SEG_ITEMS)
                transfer_sample(random_sample(), PREDICTED, '0);
        end

        settle();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("light_sensor_autorange_lux_test OK");
        else
            $display("light_sensor_autorange_lux_test NOT OK");
        $finish;
    end

endmodule

### sim.f
design/lsar_pkg.sv
design/lsar_if.sv
design/lsar_front.sv
design/lsar_fifo.sv
design/lsar_back.sv
design/light_sensor_autorange_lux.sv
tb/light_sensor_autorange_lux_test.sv
